[rtl/core/hlagc_pkg.sv]
// ----------------------------------------------------------------------------
// hlagc_pkg
// Shared types and constants for the histogram linear AGC block.
// ----------------------------------------------------------------------------
package hlagc_pkg;

	localparam int PIXEL_BITS = 16;
	localparam int NBINS      = 1 << PIXEL_BITS;
	localparam int COUNT_BITS = 17;
	localparam int AVG_FRAMES = 16;
	localparam int SLOT_BITS  = $clog2(AVG_FRAMES);
	localparam int SUM_BITS   = PIXEL_BITS + SLOT_BITS;
	localparam int CNT_BITS   = PIXEL_BITS + 1;
	localparam int OUT_BITS   = 8;
	localparam int OUT_MAX    = 255;
	localparam int THR_BITS   = 17;
	localparam int ADDR_BITS  = 4;
	localparam int DATA_BITS  = 32;

	typedef logic [PIXEL_BITS-1:0] pix_t;

	typedef struct packed {
		logic [15:0] pixel;
		logic        frame_end;
	} item_t;

	typedef struct packed {
		logic [OUT_BITS-1:0] mapped_pixel;
		logic                mapped_frame_end;
	} result_t;

	typedef struct packed {
		logic [THR_BITS-1:0] min_threshold;
		logic [THR_BITS-1:0] max_threshold;
		logic                averaging_on;
	} cfg_t;

	typedef enum logic [1:0] {
		REG_MIN = 2'd0,
		REG_MAX = 2'd1,
		REG_AVG = 2'd2
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PIX,
		ST_SCAN,
		ST_RING,
		ST_SUM,
		ST_DIFF,
		ST_DIV,
		ST_BUILD
	} eng_state_t;

endpackage

[rtl/core/hlagc_front.sv]
// ----------------------------------------------------------------------------
// hlagc_front
// Two-entry input queue; takes pixel requests and hands them to the engine.
// ----------------------------------------------------------------------------
module hlagc_front import hlagc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  logic  [15:0] pixel,
	input  logic  frame_end,
	input  logic  hold,
	output logic  full,
	output item_t deq_item,
	output logic  deq_vld,
	input  logic  deq_pop
);

	item_t      slot_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       enq;

	// refuse requests while the engine clears its memories after reset
	assign full     = (cnt_q == 2'd2) || hold;
	assign enq      = push && !full;
	assign deq_vld  = (cnt_q != 2'd0);
	assign deq_item = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (enq) begin
			slot_q[wr_q] <= '{pixel: pixel, frame_end: frame_end};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (enq) wr_q <= !wr_q;
			if (deq_pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + {1'b0, enq} - {1'b0, deq_pop};
		end
	end

endmodule

[rtl/core/hlagc_outq.sv]
// ----------------------------------------------------------------------------
// hlagc_outq
// Two-entry result queue between the engine and the result port.
// ----------------------------------------------------------------------------
module hlagc_outq import hlagc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    enq,
	input  result_t enq_data,
	output logic    space,
	output logic    empty,
	input  logic    pop,
	output result_t head
);

	result_t    slot_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       deq;

	assign space = (cnt_q != 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign deq   = pop && !empty;
	assign head  = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (enq) begin
			slot_q[wr_q] <= enq_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (enq) wr_q <= !wr_q;
			if (deq) rd_q <= !rd_q;
			cnt_q <= cnt_q + {1'b0, enq} - {1'b0, deq};
		end
	end

endmodule

[rtl/core/hlagc_engine.sv]
// ----------------------------------------------------------------------------
// hlagc_engine
// Histogram and map table memories, pixel lookup, and the frame-end sequence:
// bound scan with histogram clear, ring update, averaging, step division and
// table rebuild.
// ----------------------------------------------------------------------------
module hlagc_engine import hlagc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  item_t   in_item,
	input  logic    in_vld,
	output logic    in_pop,
	output result_t res,
	output logic    res_push,
	input  logic    res_space,
	output logic    clearing
);

	eng_state_t state_q, state_d;

	logic [CNT_BITS-1:0]   cnt_q;
	pix_t                  pix_q;
	logic                  fe_q;

	logic [COUNT_BITS-1:0] bin_mem [NBINS];
	logic [OUT_BITS-1:0]   map_mem [NBINS];
	logic [COUNT_BITS-1:0] bin_rd_q;
	logic [OUT_BITS-1:0]   map_rd_q;

	pix_t                  bin_raddr;
	pix_t                  bin_waddr;
	logic                  bin_we;
	logic [COUNT_BITS-1:0] bin_wdata;
	pix_t                  map_raddr;
	logic                  map_we;
	logic [OUT_BITS-1:0]   map_wdata;

	pix_t                  lo_q, hi_q;
	logic                  lo_found_q;
	pix_t                  low_ring_q  [AVG_FRAMES];
	pix_t                  high_ring_q [AVG_FRAMES];
	logic [SLOT_BITS-1:0]  slot_q;
	logic [SUM_BITS-1:0]   sum_lo_q, sum_hi_q;
	logic [SUM_BITS-1:0]   sum_lo_n, sum_hi_n;

	pix_t                  diff_q;
	pix_t                  rem_q;
	logic [OUT_BITS-1:0]   qs_q;
	logic [PIXEL_BITS:0]   rem_t;
	logic                  rem_ge;
	pix_t                  rem_n;

	logic [OUT_BITS-1:0]   accq_q;
	pix_t                  accr_q;
	logic [OUT_BITS:0]     qsum;
	logic [PIXEL_BITS:0]   rsum;
	logic                  wrap;
	pix_t                  rnext;
	logic [OUT_BITS-1:0]   qnext;
	logic                  above;

	pix_t                  idx;
	pix_t                  scan_idx;
	logic                  last;
	logic                  cnt_top;

	assign idx      = cnt_q[PIXEL_BITS-1:0];
	assign scan_idx = idx - 1'b1;
	assign last     = (cnt_q == CNT_BITS'(NBINS - 1));
	assign cnt_top  = (cnt_q == CNT_BITS'(NBINS));
	assign clearing = (state_q == ST_CLEAR);
	assign map_raddr = in_item.pixel[PIXEL_BITS-1:0];

	assign sum_lo_n = sum_lo_q + SUM_BITS'(low_ring_q[cnt_q[SLOT_BITS-1:0]]);
	assign sum_hi_n = sum_hi_q + SUM_BITS'(high_ring_q[cnt_q[SLOT_BITS-1:0]]);

	// the dividend 255 is all ones, so every step shifts in a one
	assign rem_t  = {rem_q, 1'b1};
	assign rem_ge = (rem_t >= {1'b0, diff_q});
	assign rem_n  = rem_ge ? PIXEL_BITS'(rem_t - {1'b0, diff_q}) : rem_t[PIXEL_BITS-1:0];

	// advance floor((i-lo)*255/diff) by one step of quotient qs_q, remainder rem_q
	assign above = (idx > lo_q);
	assign rsum  = {1'b0, accr_q} + {1'b0, rem_q};
	assign wrap  = (rsum >= {1'b0, diff_q});
	assign rnext = wrap ? PIXEL_BITS'(rsum - {1'b0, diff_q}) : rsum[PIXEL_BITS-1:0];
	assign qsum  = {1'b0, accq_q} + {1'b0, qs_q} + {{OUT_BITS{1'b0}}, wrap};
	assign qnext = (qsum > (OUT_BITS+1)'(OUT_MAX)) ? OUT_BITS'(OUT_MAX) : qsum[OUT_BITS-1:0];

	assign res = '{mapped_pixel: map_rd_q, mapped_frame_end: fe_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_pop    = 1'b0;
		res_push  = 1'b0;
		bin_raddr = in_item.pixel[PIXEL_BITS-1:0];
		bin_we    = 1'b0;
		bin_waddr = idx;
		bin_wdata = '0;
		map_we    = 1'b0;
		map_wdata = '0;
		unique case (state_q)
			ST_CLEAR: begin
				bin_we = 1'b1;
				map_we = 1'b1;
				if (last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_vld && res_space) begin
					in_pop  = 1'b1;
					state_d = ST_PIX;
				end
			end
			ST_PIX: begin
				bin_we    = 1'b1;
				bin_waddr = pix_q;
				bin_wdata = (bin_rd_q == '1) ? bin_rd_q : bin_rd_q + 1'b1;
				res_push  = 1'b1;
				state_d   = fe_q ? ST_SCAN : ST_IDLE;
			end
			ST_SCAN: begin
				if (cnt_top) begin
					state_d = ST_RING;
				end else begin
					bin_raddr = idx;
					bin_we    = 1'b1;
				end
			end
			ST_RING: begin
				state_d = cfg.averaging_on ? ST_SUM : ST_DIFF;
			end
			ST_SUM: begin
				if (cnt_q[SLOT_BITS-1:0] == SLOT_BITS'(AVG_FRAMES - 1)) state_d = ST_DIFF;
			end
			ST_DIFF: begin
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (cnt_q[2:0] == 3'(OUT_BITS - 1)) state_d = ST_BUILD;
			end
			ST_BUILD: begin
				map_we    = 1'b1;
				map_wdata = above ? qnext : '0;
				if (last) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (bin_we) bin_mem[bin_waddr] <= bin_wdata;
		bin_rd_q <= bin_mem[bin_raddr];
	end

	always_ff @(posedge clk) begin
		if (map_we) map_mem[idx] <= map_wdata;
		map_rd_q <= map_mem[map_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (state_d != state_q) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			for (int i = 0; i < AVG_FRAMES; i++) begin
				low_ring_q[i]  <= '0;
				high_ring_q[i] <= '0;
			end
		end else if (state_q == ST_RING) begin
			low_ring_q[slot_q]  <= lo_q;
			high_ring_q[slot_q] <= hi_q;
			slot_q <= (slot_q == SLOT_BITS'(AVG_FRAMES - 1)) ? '0 : slot_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_pop) begin
			pix_q <= in_item.pixel[PIXEL_BITS-1:0];
			fe_q  <= in_item.frame_end;
		end
		case (state_q)
			ST_PIX: begin
				lo_q       <= '0;
				hi_q       <= '0;
				lo_found_q <= 1'b0;
			end
			ST_SCAN: begin
				// read data is registered, so bin_rd_q holds the count for the previous address
				if (cnt_q != '0) begin
					if (!lo_found_q && bin_rd_q > cfg.min_threshold) begin
						lo_q       <= scan_idx;
						lo_found_q <= 1'b1;
					end
					if (bin_rd_q > cfg.max_threshold) hi_q <= scan_idx;
				end
			end
			ST_RING: begin
				sum_lo_q <= '0;
				sum_hi_q <= '0;
			end
			ST_SUM: begin
				sum_lo_q <= sum_lo_n;
				sum_hi_q <= sum_hi_n;
				if (state_d == ST_DIFF) begin
					lo_q <= PIXEL_BITS'(sum_lo_n / AVG_FRAMES);
					hi_q <= PIXEL_BITS'(sum_hi_n / AVG_FRAMES);
				end
			end
			ST_DIFF: begin
				diff_q <= (hi_q > lo_q) ? hi_q - lo_q : PIXEL_BITS'(1);
				rem_q  <= '0;
				qs_q   <= '0;
				accq_q <= '0;
				accr_q <= '0;
			end
			ST_DIV: begin
				rem_q <= rem_n;
				qs_q  <= {qs_q[OUT_BITS-2:0], rem_ge};
			end
			ST_BUILD: begin
				accq_q <= above ? qnext : '0;
				accr_q <= above ? rnext : '0;
			end
			default: begin
			end
		endcase
	end

endmodule

[rtl/core/histogram_linear_agc.sv]
// ----------------------------------------------------------------------------
// histogram_linear_agc
// Maps 16-bit infrared pixels to 8 bits through a table rebuilt from each
// frame's histogram.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake           Payload
// config    in/out     psel/penable/pready paddr, pwdata, prdata
// pixels    in         push / full         pixel, frame_end
// results   out        pop / empty         mapped_pixel, mapped_frame_end
//
// Each pixel is read from the table and the histogram, then its count is
// written back; a new pixel is taken only after the write-back and only
// while the result queue has space.
// A frame end then runs a histogram scan with clear, a ring update, the
// ring average (only when averaging is on), a step division and a table
// rebuild. After reset a pass clears both memories; full stays high meanwhile.
// Both sides stall independently through two-entry queues.
// ----------------------------------------------------------------------------
module histogram_linear_agc import hlagc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [DATA_BITS-1:0] pwdata,
	output logic [DATA_BITS-1:0] prdata,
	output logic                 pready,
	input  logic                 push,
	output logic                 full,
	input  logic [15:0]          pixel,
	input  logic                 frame_end,
	output logic                 empty,
	input  logic                 pop,
	output logic [OUT_BITS-1:0]  mapped_pixel,
	output logic                 mapped_frame_end
);

	cfg_t     cfg_q;
	reg_idx_t reg_idx;
	logic     wr_en;
	item_t    deq_item;
	logic     deq_vld;
	logic     deq_pop;
	result_t  res;
	logic     res_push;
	logic     res_space;
	logic     clearing;
	result_t  head;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_threshold <= THR_BITS'(5);
			cfg_q.max_threshold <= THR_BITS'(5);
			cfg_q.averaging_on  <= 1'b1;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_MIN: cfg_q.min_threshold <= pwdata[THR_BITS-1:0];
				REG_MAX: cfg_q.max_threshold <= pwdata[THR_BITS-1:0];
				REG_AVG: cfg_q.averaging_on  <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_MIN: prdata = DATA_BITS'(cfg_q.min_threshold);
			REG_MAX: prdata = DATA_BITS'(cfg_q.max_threshold);
			REG_AVG: prdata = DATA_BITS'(cfg_q.averaging_on);
			default: prdata = '0;
		endcase
	end

	hlagc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.pixel    (pixel),
		.frame_end(frame_end),
		.hold     (clearing),
		.full     (full),
		.deq_item (deq_item),
		.deq_vld  (deq_vld),
		.deq_pop  (deq_pop)
	);

	hlagc_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_item  (deq_item),
		.in_vld   (deq_vld),
		.in_pop   (deq_pop),
		.res      (res),
		.res_push (res_push),
		.res_space(res_space),
		.clearing (clearing)
	);

	hlagc_outq u_outq (
		.clk     (clk),
		.arst_n  (arst_n),
		.enq     (res_push),
		.enq_data(res),
		.space   (res_space),
		.empty   (empty),
		.pop     (pop),
		.head    (head)
	);

	assign mapped_pixel     = head.mapped_pixel;
	assign mapped_frame_end = head.mapped_frame_end;

endmodule

[rtl/core/hlagc_checker.sv]
// ----------------------------------------------------------------------------
// hlagc_checker
// Port-level checks on the AGC top level, bound to every instance.
// ----------------------------------------------------------------------------
module hlagc_checker import hlagc_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 psel,
	input logic                 penable,
	input logic                 pwrite,
	input logic [ADDR_BITS-1:0] paddr,
	input logic [DATA_BITS-1:0] pwdata,
	input logic [DATA_BITS-1:0] prdata,
	input logic                 pready,
	input logic                 empty,
	input logic                 pop,
	input logic [OUT_BITS-1:0]  mapped_pixel,
	input logic                 mapped_frame_end
);

	// a waiting result stays until popped
	a_res_held: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty)
		else $error("result dropped before pop");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> $stable(mapped_pixel) && $stable(mapped_frame_end))
		else $error("waiting result changed");

	// a min_threshold write is read back by a read of that register straight after it
	a_min_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready && paddr[3:2] == REG_MIN |=>
		!(psel && !pwrite && paddr[3:2] == REG_MIN) ||
		prdata[THR_BITS-1:0] == $past(pwdata[THR_BITS-1:0]))
		else $error("min_threshold readback mismatch");

	a_avg_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready && paddr[3:2] == REG_AVG |=>
		!(psel && !pwrite && paddr[3:2] == REG_AVG) || prdata[0] == $past(pwdata[0]))
		else $error("averaging_on readback mismatch");

	a_prdata_upper: assert property (@(posedge clk) disable iff (!arst_n)
		prdata[DATA_BITS-1:THR_BITS] == '0)
		else $error("unused read bits set");

endmodule

bind histogram_linear_agc hlagc_checker u_hlagc_checker (.*);
